// File: sv/mcgm_pkg.sv
// Shared types, constants and result builders for the multicast membership table.
package mcgm_pkg;

  // Widths of the fixed payload fields.
  localparam int SLOT_W  = 5;
  localparam int ADDR_W  = 32;
  localparam int IDENT_W = 16;
  localparam int TIMER_W = 8;

  // At most this many reports leave for one timer tick.
  localparam int MAX_RESULTS = 20;
  localparam int REP_W       = $clog2(MAX_RESULTS + 1);

  // Protocol constants.
  localparam logic [ADDR_W-1:0]  ALL_HOSTS             = 32'hE000_0001;
  localparam logic [3:0]         MCAST_PREFIX          = 4'hE;
  localparam logic [7:0]         IPV4_VERSION_IHL      = 8'h45;
  localparam logic [7:0]         IGMP_MEMBERSHIP_QUERY = 8'h11;
  localparam logic [TIMER_W-1:0] JOIN_TIMER            = 8'd2;

  // Request kinds.
  typedef enum logic [1:0] {
    KIND_JOIN  = 2'd0,
    KIND_LEAVE = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_TICK  = 2'd3
  } kind_t;

  // Result kinds.
  typedef enum logic [1:0] {
    RES_STATUS = 2'd0,
    RES_REPORT = 2'd1,
    RES_LEAVE  = 2'd2
  } result_kind_t;

  // Call status codes.
  typedef enum logic [1:0] {
    STATUS_OK            = 2'd0,
    STATUS_NOT_MULTICAST = 2'd1,
    STATUS_TABLE_FULL    = 2'd2,
    STATUS_NOT_FOUND     = 2'd3
  } status_t;

  // Membership state of one table entry.
  typedef enum logic [1:0] {
    MEMBER_NONE     = 2'd0,
    MEMBER_DELAYING = 2'd1,
    MEMBER_IDLE     = 2'd2
  } member_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_JOIN_ADD,
    ST_JOIN_OK,
    ST_LEAVE_OK,
    ST_FLUSH
  } state_t;

  // One request item.
  typedef struct packed {
    kind_t             kind;
    logic [ADDR_W-1:0] address;
    logic [7:0]        header_version_ihl;
    logic [7:0]        message_type;
    logic [7:0]        max_response;
  } in_item_t;

  // One result item.
  typedef struct packed {
    result_kind_t       result_kind;
    status_t            status;
    logic [SLOT_W-1:0]  slot;
    logic [ADDR_W-1:0]  group;
    logic [IDENT_W-1:0] packet_ident;
    logic               last;
  } out_item_t;

  // One word of the membership memory.
  typedef struct packed {
    logic [ADDR_W-1:0]  group;
    member_t            state;
    logic [TIMER_W-1:0] timer;
  } entry_t;

  localparam entry_t ENTRY_CLEAR = '{group: '0, state: MEMBER_NONE, timer: '0};

  // Build a call status result.
  function automatic out_item_t make_status(input status_t st,
                                            input logic [SLOT_W-1:0] slot);
    out_item_t r;
    r              = '0;
    r.result_kind  = RES_STATUS;
    r.status       = st;
    r.slot         = slot;
    return r;
  endfunction

  // Build a report or leave message result.
  function automatic out_item_t make_msg(input result_kind_t k,
                                         input logic [SLOT_W-1:0] slot,
                                         input logic [ADDR_W-1:0] group,
                                         input logic [IDENT_W-1:0] ident);
    out_item_t r;
    r              = '0;
    r.result_kind  = k;
    r.status       = STATUS_OK;
    r.slot         = slot;
    r.group        = group;
    r.packet_ident = ident;
    return r;
  endfunction

endpackage

// File: sv/mcgm_table_mem.sv
// Membership table memory: one write port, one read port with registered data.
module mcgm_table_mem import mcgm_pkg::*; #(
  parameter int DEPTH = 20,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data
);

  entry_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/mcgm_ctrl.sv
// Controller: scans the table one entry per cycle unless stalled, and builds the result items.
module mcgm_ctrl import mcgm_pkg::*; #(
  parameter int TABLE_ENTRIES = 20,
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             request_valid,
  output logic             request_ready,
  input  in_item_t         request,
  output logic             rd_en,
  output logic [IDX_W-1:0] rd_addr,
  input  entry_t           rd_data,
  output logic             wr_en,
  output logic [IDX_W-1:0] wr_addr,
  output entry_t           wr_data,
  input  logic             can_push,
  output logic             push,
  output out_item_t        push_item
);

  state_t              state, state_next;
  in_item_t            req_q, req_next;
  logic [IDX_W-1:0]    scan_idx, scan_idx_next;
  logic [CNT_W-1:0]    used, used_next;
  logic [IDENT_W-1:0]  ident, ident_next;
  logic [REP_W-1:0]    rep_count, rep_next;
  logic                pend_valid, pend_valid_next;
  out_item_t           pend, pend_next;

  entry_t              ent;
  logic                live, hit, q_match, at_end, expire_ok;
  logic                is_mcast, is_full, query_ok, table_empty;
  logic                put, blocked;
  out_item_t           put_item;
  logic [TIMER_W-1:0]  newt;

  assign request_ready = (state == ST_IDLE);

  // Per-entry decisions and the result that this cycle wants to queue.
  always_comb begin
    ent         = rd_data;
    live        = (ent.state != MEMBER_NONE);
    hit         = live && (ent.group == req_q.address);
    q_match     = live && ((req_q.address == ALL_HOSTS) || (ent.group == req_q.address));
    at_end      = ((CNT_W'(scan_idx) + CNT_W'(1)) == used);
    expire_ok   = (ent.state == MEMBER_DELAYING) && (ent.timer == TIMER_W'(1)) &&
                  (rep_count < REP_W'(MAX_RESULTS));
    newt        = TIMER_W'(1) + {1'b0, req_q.max_response[7:1]};
    is_mcast    = (request.address[ADDR_W-1:ADDR_W-4] == MCAST_PREFIX);
    is_full     = (used >= CNT_W'(TABLE_ENTRIES));
    table_empty = (used == '0);
    query_ok    = (request.header_version_ihl == IPV4_VERSION_IHL) &&
                  (request.message_type == IGMP_MEMBERSHIP_QUERY);
    put         = 1'b0;
    put_item    = '0;
    unique case (state)
      ST_IDLE: begin
        if (request_valid) begin
          unique case (request.kind)
            KIND_JOIN: begin
              if (!is_mcast) begin
                put      = 1'b1;
                put_item = make_status(STATUS_NOT_MULTICAST, '0);
              end else if (is_full) begin
                put      = 1'b1;
                put_item = make_status(STATUS_TABLE_FULL, '0);
              end
            end
            KIND_LEAVE: begin
              if (table_empty) begin
                put      = 1'b1;
                put_item = make_status(STATUS_NOT_FOUND, '0);
              end
            end
            KIND_QUERY, KIND_TICK: ;
          endcase
        end
      end
      ST_SCAN: begin
        unique case (req_q.kind)
          KIND_JOIN: begin
            if (hit) begin
              put      = 1'b1;
              put_item = make_status(STATUS_OK, SLOT_W'(scan_idx));
            end
          end
          KIND_LEAVE: begin
            if (hit) begin
              put      = 1'b1;
              put_item = make_msg(RES_LEAVE, SLOT_W'(scan_idx), req_q.address, ident);
            end else if (at_end) begin
              put      = 1'b1;
              put_item = make_status(STATUS_NOT_FOUND, '0);
            end
          end
          KIND_TICK: begin
            if (expire_ok) begin
              put      = 1'b1;
              put_item = make_msg(RES_REPORT, SLOT_W'(scan_idx), ent.group, ident);
            end
          end
          KIND_QUERY: ;
        endcase
      end
      ST_JOIN_ADD: begin
        put      = 1'b1;
        put_item = make_msg(RES_REPORT, SLOT_W'(used), req_q.address, ident);
      end
      ST_JOIN_OK: begin
        put      = 1'b1;
        put_item = make_status(STATUS_OK, SLOT_W'(scan_idx));
      end
      ST_LEAVE_OK: begin
        put      = 1'b1;
        put_item = make_status(STATUS_OK, '0);
      end
      ST_FLUSH: ;
      default: ;
    endcase
    // A queued result must first move its predecessor into the output register.
    blocked = (put || (state == ST_FLUSH)) && pend_valid && !can_push;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (request_valid) begin
          unique case (request.kind)
            KIND_JOIN: begin
              if (!is_mcast || is_full) begin
                state_next = ST_FLUSH;
              end else if (table_empty) begin
                state_next = ST_JOIN_ADD;
              end else begin
                state_next = ST_SCAN;
              end
            end
            KIND_LEAVE: state_next = table_empty ? ST_FLUSH : ST_SCAN;
            KIND_QUERY: state_next = (query_ok && !table_empty) ? ST_SCAN : ST_IDLE;
            KIND_TICK:  state_next = table_empty ? ST_IDLE : ST_SCAN;
          endcase
        end
      end
      ST_SCAN: begin
        if (!blocked) begin
          unique case (req_q.kind)
            KIND_JOIN: begin
              if (hit) begin
                state_next = ST_FLUSH;
              end else if (at_end) begin
                state_next = ST_JOIN_ADD;
              end
            end
            KIND_LEAVE: begin
              if (hit) begin
                state_next = ST_LEAVE_OK;
              end else if (at_end) begin
                state_next = ST_FLUSH;
              end
            end
            KIND_QUERY: if (at_end) state_next = ST_IDLE;
            KIND_TICK:  if (at_end) state_next = ST_FLUSH;
          endcase
        end
      end
      ST_JOIN_ADD: state_next = ST_JOIN_OK;
      ST_JOIN_OK, ST_LEAVE_OK: if (!blocked) state_next = ST_FLUSH;
      ST_FLUSH: if (!blocked) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory accesses, table updates and result queueing.
  always_comb begin
    rd_en           = 1'b0;
    rd_addr         = scan_idx;
    wr_en           = 1'b0;
    wr_addr         = scan_idx;
    wr_data         = ent;
    push            = 1'b0;
    push_item       = pend;
    req_next        = req_q;
    scan_idx_next   = scan_idx;
    used_next       = used;
    ident_next      = ident;
    rep_next        = rep_count;
    pend_next       = pend;
    pend_valid_next = pend_valid;
    unique case (state)
      ST_IDLE: begin
        if (request_valid) begin
          req_next      = request;
          rep_next      = '0;
          scan_idx_next = '0;
          rd_en         = 1'b1;
          rd_addr       = '0;
        end
      end
      ST_SCAN: begin
        if (blocked) begin
          // Hold the entry: read it again for the next cycle.
          rd_en   = 1'b1;
          rd_addr = scan_idx;
        end else begin
          if (!at_end) begin
            rd_en         = 1'b1;
            rd_addr       = scan_idx + IDX_W'(1);
            scan_idx_next = scan_idx + IDX_W'(1);
          end
          unique case (req_q.kind)
            KIND_LEAVE: begin
              if (hit) begin
                wr_en      = 1'b1;
                wr_data    = ENTRY_CLEAR;
                ident_next = ident + IDENT_W'(1);
              end
            end
            KIND_QUERY: begin
              if (q_match) begin
                if (ent.state == MEMBER_DELAYING) begin
                  if (req_q.max_response < ent.timer) begin
                    wr_en         = 1'b1;
                    wr_data.timer = newt;
                  end
                end else begin
                  wr_en         = 1'b1;
                  wr_data.state = MEMBER_DELAYING;
                  wr_data.timer = newt;
                end
              end
            end
            KIND_TICK: begin
              if ((ent.state == MEMBER_DELAYING) && (ent.timer != '0)) begin
                if (ent.timer == TIMER_W'(1)) begin
                  if (expire_ok) begin
                    wr_en         = 1'b1;
                    wr_data.state = MEMBER_IDLE;
                    wr_data.timer = '0;
                    ident_next    = ident + IDENT_W'(1);
                    rep_next      = rep_count + REP_W'(1);
                  end
                end else begin
                  wr_en         = 1'b1;
                  wr_data.timer = ent.timer - TIMER_W'(1);
                end
              end
            end
            KIND_JOIN: ;
          endcase
        end
      end
      ST_JOIN_ADD: begin
        // Append the new group behind the last used slot.
        wr_en         = 1'b1;
        wr_addr       = used[IDX_W-1:0];
        wr_data       = '{group: req_q.address, state: MEMBER_DELAYING, timer: JOIN_TIMER};
        used_next     = used + CNT_W'(1);
        ident_next    = ident + IDENT_W'(1);
        scan_idx_next = used[IDX_W-1:0];
      end
      ST_JOIN_OK, ST_LEAVE_OK: ;
      ST_FLUSH: begin
        // The held result is the final one of this item.
        if (pend_valid && can_push) begin
          push            = 1'b1;
          push_item       = pend;
          push_item.last  = 1'b1;
          pend_valid_next = 1'b0;
        end
      end
      default: ;
    endcase
    // Queue a new result, sending the held one on with last clear.
    if (put && !blocked) begin
      if (pend_valid) begin
        push      = 1'b1;
        push_item = pend;
      end
      pend_next       = put_item;
      pend_valid_next = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      scan_idx   <= '0;
      used       <= '0;
      ident      <= '0;
      rep_count  <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      scan_idx   <= scan_idx_next;
      used       <= used_next;
      ident      <= ident_next;
      rep_count  <= rep_next;
      pend_valid <= pend_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    req_q <= req_next;
    pend  <= pend_next;
  end

endmodule

// File: sv/multicast_group_membership_table.sv
// Top level of the multicast group membership table.
//
// Requests (join, leave, received query, timer tick) enter on the request
// channel; result items (call statuses, report and leave send requests)
// leave on the result channel. Both channels use valid/ready. The last flag
// marks the final result caused by one request.
// One request is handled at a time. The table sits in a single memory with
// one read port, so a request scans one entry per cycle while no result is
// blocked by a stalled receiver. A join that finds no match appends its group
// after the scan and then delivers the held results. A query with a foreign
// header, or a query or tick on an empty table, needs no scan and leaves the
// block idle. A refused join or a leave on an empty table queues its status
// on acceptance, without a scan.
// Results pass through an output register, so a new request is accepted
// while the previous result waits. When the receiver stalls, the scan holds
// at the entry that has a result to deliver and resumes when room appears.
// Reset empties the table and clears the packet ident; no clearing pass is
// needed because only slots below the fill count are ever used.
module multicast_group_membership_table import mcgm_pkg::*; #(
  parameter int TABLE_ENTRIES = 20
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      request_valid,
  output logic      request_ready,
  input  in_item_t  request,
  output logic      result_valid,
  input  logic      result_ready,
  output out_item_t result
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic             rd_en, wr_en, can_push, push;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  entry_t           rd_data, wr_data;
  out_item_t        push_item;

  mcgm_table_mem #(.DEPTH(TABLE_ENTRIES)) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  mcgm_ctrl #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_ready (request_ready),
    .request       (request),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .can_push      (can_push),
    .push          (push),
    .push_item     (push_item)
  );

  // Output register: takes an item when empty or being emptied.
  assign can_push = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (push) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      result <= push_item;
    end
  end

endmodule

// File: sv/mcgm_checker.sv
// Port-level checks for the multicast membership table, bound to the top level.
module mcgm_checker import mcgm_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      request_valid,
  input logic      request_ready,
  input in_item_t  request,
  input logic      result_valid,
  input logic      result_ready,
  input out_item_t result
);

  // A stalled result item holds its payload.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result item changed while stalled");

  // Join and leave always produce a result, so the block is busy afterwards.
  a_busy_after_join_leave: assert property (@(posedge clk) disable iff (rst)
    request_valid && request_ready &&
    (request.kind == KIND_JOIN || request.kind == KIND_LEAVE) |=> !request_ready)
    else $error("request accepted right after a join or leave");

  // A call status ends its request and carries no group or ident.
  a_status_final: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.result_kind == RES_STATUS |->
    result.last && result.group == '0 && result.packet_ident == '0)
    else $error("malformed status result");

  // A leave message is always followed by its status.
  a_leave_not_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.result_kind == RES_LEAVE |-> !result.last &&
    result.status == STATUS_OK)
    else $error("leave message marked last");

endmodule

bind multicast_group_membership_table mcgm_checker u_mcgm_checker (.*);
